/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the union-find block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/ufrpc_pkg.sv */
// Package with types and constants of the union-find block.
package ufrpc_pkg;

   // Default number of nodes held in the store.
   localparam int MAX_NODES_DEFAULT = 1024;

   // Field widths fixed by the interface.
   localparam int NODE_W  = 10;
   localparam int COUNT_W = 11;
   localparam int RANK_W  = 4;
   localparam int STAT_W  = 2;

   // Width wide enough to compare any index against any node limit.
   localparam int CMP_W = 17;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

   // Request codes.
   localparam logic REQ_UNION = 1'b0;
   localparam logic REQ_FIND  = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STATUS_FIND_DONE = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_JOINED    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SAME_SET  = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_RANGE_ERR = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_COMP,
      ST_LINK,
      ST_BUMP,
      ST_DONE
   } state_type;

endpackage

/* rtl/union_find_rank_path_compression_top.sv */
// Union-find store with union by rank and path compression, one node memory with one write port
// and one registered read port. A new request is taken only after the previous result: the
// sequencer walks the node memory one node per cycle, and the next start is taken in the cycle
// of the result strobe. After reset a clearing pass marks every node as a rank-0 root; busy
// stays high meanwhile. Results are strobed for one cycle and cannot be stalled.
module union_find_rank_path_compression_top #(
   parameter int MAX_NODES = ufrpc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [ufrpc_pkg::NODE_W-1:0]  req_node_a,
   input  logic [ufrpc_pkg::NODE_W-1:0]  req_node_b,
   output logic                          rsp_strobe,
   output logic [ufrpc_pkg::NODE_W-1:0]  rsp_root_a,
   output logic [ufrpc_pkg::NODE_W-1:0]  rsp_root_b,
   output logic [ufrpc_pkg::STAT_W-1:0]  rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ufrpc_pkg::COUNT_W-1:0] csr_node_count
);

`include "assert_macros.svh"

   localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int RANK_W = ufrpc_pkg::RANK_W;
   localparam int CMP_W  = ufrpc_pkg::CMP_W;
   localparam int ENT_W  = 1 + IDX_W + RANK_W;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_NODES - 1);
   localparam logic [IDX_W:0]   NODES_EXT = (IDX_W + 1)'(MAX_NODES);
   localparam logic [CMP_W-1:0] NODES_CMP = CMP_W'(MAX_NODES);

   // Sequencer and control registers.
   ufrpc_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ufrpc_pkg::COUNT_W-1:0] count_ff;

   // Request and datapath registers.
   logic                         type_ff, type_in;
   logic [ufrpc_pkg::NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic                         phase_b_ff, phase_b_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [IDX_W-1:0]             start_ff, start_in;
   logic [IDX_W-1:0]             root_ff, root_in;
   logic [RANK_W-1:0]            rank_ff, rank_in;
   logic [IDX_W-1:0]             ra_ff, ra_in;
   logic [RANK_W-1:0]            rank_a_ff, rank_a_in;
   logic [ufrpc_pkg::STAT_W-1:0] status_ff, status_in;

   // Result registers.
   logic [ufrpc_pkg::NODE_W-1:0] rsp_root_a_ff, rsp_root_a_in;
   logic [ufrpc_pkg::NODE_W-1:0] rsp_root_b_ff, rsp_root_b_in;
   logic [ufrpc_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;

   // Node memory: root mark, parent index and rank in one word.
   logic [ENT_W-1:0] node_mem [MAX_NODES];
   logic [ENT_W-1:0] rd_q;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic             mem_we;

   logic              rd_root;
   logic [IDX_W-1:0]  rd_parent;
   logic [RANK_W-1:0] rd_rank;
   logic              rd_has_parent;

   logic              accept;
   logic [CMP_W-1:0]  node_lim;
   logic              range_err;
   logic [IDX_W-1:0]  cmp_x, cmp_y;
   logic              cmp_eq;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ufrpc_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Fields of the word read in the previous cycle.
   assign rd_root       = rd_q[ENT_W-1];
   assign rd_parent     = rd_q[ENT_W-2 -: IDX_W];
   assign rd_rank       = rd_q[RANK_W-1:0];
   assign rd_has_parent = !rd_root && ({1'b0, rd_parent} < NODES_EXT);

   // Index check against the smaller of the configured count and the store size.
   assign node_lim  = (CMP_W'(count_ff) < NODES_CMP) ? CMP_W'(count_ff) : NODES_CMP;
   assign range_err = (CMP_W'(a_ff) >= node_lim) ||
                      ((type_ff == ufrpc_pkg::REQ_UNION) && (CMP_W'(b_ff) >= node_lim));

   // Shared equality unit: end of compression, or same-root test when linking.
   always_comb begin
      if (state_ff == ufrpc_pkg::ST_LINK) begin
         cmp_x = ra_ff;
         cmp_y = root_ff;
      end else begin
         cmp_x = cur_ff;
         cmp_y = root_ff;
      end
   end
   assign cmp_eq = (cmp_x == cmp_y);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ufrpc_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX) state_in = ufrpc_pkg::ST_IDLE;
         end
         ufrpc_pkg::ST_IDLE: begin
            if (accept) state_in = ufrpc_pkg::ST_CHECK;
         end
         ufrpc_pkg::ST_CHECK: begin
            state_in = range_err ? ufrpc_pkg::ST_DONE : ufrpc_pkg::ST_WALK;
         end
         ufrpc_pkg::ST_WALK: begin
            if (!rd_has_parent) state_in = ufrpc_pkg::ST_COMP;
         end
         ufrpc_pkg::ST_COMP: begin
            if (cmp_eq || !rd_has_parent) begin
               if (phase_b_ff) begin
                  state_in = ufrpc_pkg::ST_LINK;
               end else if (type_ff == ufrpc_pkg::REQ_FIND) begin
                  state_in = ufrpc_pkg::ST_DONE;
               end else begin
                  state_in = ufrpc_pkg::ST_WALK;
               end
            end
         end
         ufrpc_pkg::ST_LINK: begin
            if (!cmp_eq && !(rank_a_ff > rank_ff) && (rank_a_ff == rank_ff) &&
                (rank_ff != ufrpc_pkg::RANK_MAX)) begin
               state_in = ufrpc_pkg::ST_BUMP;
            end else begin
               state_in = ufrpc_pkg::ST_DONE;
            end
         end
         ufrpc_pkg::ST_BUMP: state_in = ufrpc_pkg::ST_DONE;
         ufrpc_pkg::ST_DONE: state_in = ufrpc_pkg::ST_IDLE;
         default:            state_in = ufrpc_pkg::ST_CLEAR;
      endcase
   end

   // Memory controls and datapath updates of each state.
   always_comb begin
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      type_in       = type_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      phase_b_in    = phase_b_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      root_in       = root_ff;
      rank_in       = rank_ff;
      ra_in         = ra_ff;
      rank_a_in     = rank_a_ff;
      status_in     = status_ff;
      rsp_root_a_in = rsp_root_a_ff;
      rsp_root_b_in = rsp_root_b_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = cur_ff;
      wr_addr       = cur_ff;
      wr_data       = {1'b1, {IDX_W{1'b0}}, {RANK_W{1'b0}}};
      mem_we        = 1'b0;
      case (state_ff)
         // Mark one node a cycle as a rank-0 root.
         ufrpc_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         // Capture the request on a start transfer.
         ufrpc_pkg::ST_IDLE: begin
            if (accept) begin
               type_in = req_type;
               a_in    = req_node_a;
               b_in    = req_node_b;
            end
         end
         // Reject out-of-range indices, else start the walk from node_a.
         ufrpc_pkg::ST_CHECK: begin
            phase_b_in = 1'b0;
            if (range_err) begin
               status_in = ufrpc_pkg::STATUS_RANGE_ERR;
            end else begin
               rd_addr  = IDX_W'(a_ff);
               cur_in   = IDX_W'(a_ff);
               start_in = IDX_W'(a_ff);
            end
         end
         // Follow parent links one node a cycle until a root shows up.
         ufrpc_pkg::ST_WALK: begin
            if (rd_has_parent) begin
               rd_addr = rd_parent;
               cur_in  = rd_parent;
            end else begin
               root_in = cur_ff;
               rank_in = rd_rank;
               rd_addr = start_ff;
               cur_in  = start_ff;
            end
         end
         // Relink each node of the walked path straight to the root.
         ufrpc_pkg::ST_COMP: begin
            if (!cmp_eq && rd_has_parent) begin
               mem_we  = 1'b1;
               wr_addr = cur_ff;
               wr_data = {1'b0, root_ff, rd_rank};
               rd_addr = rd_parent;
               cur_in  = rd_parent;
            end else if (!phase_b_ff) begin
               ra_in     = root_ff;
               rank_a_in = rank_ff;
               if (type_ff == ufrpc_pkg::REQ_FIND) begin
                  status_in = ufrpc_pkg::STATUS_FIND_DONE;
               end else begin
                  phase_b_in = 1'b1;
                  rd_addr    = IDX_W'(b_ff);
                  cur_in     = IDX_W'(b_ff);
                  start_in   = IDX_W'(b_ff);
               end
            end
         end
         // Join the two roots by rank.
         ufrpc_pkg::ST_LINK: begin
            if (cmp_eq) begin
               status_in = ufrpc_pkg::STATUS_SAME_SET;
            end else begin
               status_in = ufrpc_pkg::STATUS_JOINED;
               mem_we    = 1'b1;
               if (rank_a_ff > rank_ff) begin
                  wr_addr = root_ff;
                  wr_data = {1'b0, ra_ff, rank_ff};
               end else begin
                  wr_addr = ra_ff;
                  wr_data = {1'b0, root_ff, rank_a_ff};
               end
            end
         end
         // Equal ranks: the surviving root gains one rank.
         ufrpc_pkg::ST_BUMP: begin
            mem_we  = 1'b1;
            wr_addr = root_ff;
            wr_data = {1'b1, {IDX_W{1'b0}}, rank_ff + RANK_W'(1)};
         end
         // Load the result registers for a one-cycle strobe.
         ufrpc_pkg::ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = status_ff;
            if (status_ff == ufrpc_pkg::STATUS_RANGE_ERR) begin
               rsp_root_a_in = '0;
            end else begin
               rsp_root_a_in = ufrpc_pkg::NODE_W'(ra_ff);
            end
            if ((status_ff == ufrpc_pkg::STATUS_JOINED) ||
                (status_ff == ufrpc_pkg::STATUS_SAME_SET)) begin
               rsp_root_b_in = ufrpc_pkg::NODE_W'(root_ff);
            end else begin
               rsp_root_b_in = '0;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ufrpc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= ufrpc_pkg::COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) count_ff <= csr_node_count;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      phase_b_ff    <= phase_b_in;
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      root_ff       <= root_in;
      rank_ff       <= rank_in;
      ra_ff         <= ra_in;
      rank_a_ff     <= rank_a_in;
      status_ff     <= status_in;
      rsp_root_a_ff <= rsp_root_a_in;
      rsp_root_b_ff <= rsp_root_b_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Node memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) node_mem[wr_addr] <= wr_data;
      rd_q <= node_mem[rd_addr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_root_a = rsp_root_a_ff;
   assign rsp_root_b = rsp_root_b_ff;
   assign rsp_status = rsp_status_ff;

   // The result-load state is always followed by a result strobe.
   `ASSERT_NEXT(a_strobe_after_done, clock, reset,
      state_ff == ufrpc_pkg::ST_DONE, rsp_strobe_ff)
   // A transfer on start always enters the index check next.
   `ASSERT_NEXT(a_accept_to_check, clock, reset, accept, state_ff == ufrpc_pkg::ST_CHECK)
   // Two nodes already in one set never cause a link write.
   `ASSERT_IMPLIES(a_no_self_link, clock, reset,
      state_ff == ufrpc_pkg::ST_LINK && ra_ff == root_ff, !mem_we)
   // A rejected request reports zero roots.
   `ASSERT_IMPLIES(a_err_roots_zero, clock, reset,
      rsp_strobe_ff && rsp_status_ff == ufrpc_pkg::STATUS_RANGE_ERR,
      rsp_root_a_ff == '0 && rsp_root_b_ff == '0)

endmodule

/* tb/sv/tb_union_find_rank_path_compression_top.sv */
// Self-checking testbench for the union-find block with union by rank and path compression.
`timescale 1ns / 100ps

module tb_union_find_rank_path_compression_top;

   localparam int NODES = ufrpc_pkg::MAX_NODES_DEFAULT;

   // One request as the driver presents it.
   typedef struct packed {
      logic                         op;
      logic [ufrpc_pkg::NODE_W-1:0] node_a;
      logic [ufrpc_pkg::NODE_W-1:0] node_b;
   } set_request_type;

   // One predicted reply of the block.
   typedef struct packed {
      logic [ufrpc_pkg::NODE_W-1:0] root_a;
      logic [ufrpc_pkg::NODE_W-1:0] root_b;
      logic [ufrpc_pkg::STAT_W-1:0] status;
   } set_reply_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_type = ufrpc_pkg::REQ_FIND;
   logic [ufrpc_pkg::NODE_W-1:0]  req_node_a = '0;
   logic [ufrpc_pkg::NODE_W-1:0]  req_node_b = '0;
   logic                          rsp_strobe;
   logic [ufrpc_pkg::NODE_W-1:0]  rsp_root_a;
   logic [ufrpc_pkg::NODE_W-1:0]  rsp_root_b;
   logic [ufrpc_pkg::STAT_W-1:0]  rsp_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ufrpc_pkg::COUNT_W-1:0] csr_node_count = '0;

   // Shadow copy of the forest and of the node count register.
   logic [ufrpc_pkg::NODE_W-1:0]  shadow_parent [NODES];
   logic                          shadow_is_root [NODES];
   logic [ufrpc_pkg::RANK_W-1:0]  shadow_rank [NODES];
   logic [ufrpc_pkg::COUNT_W-1:0] shadow_count;

   set_request_type     request_backlog[$];
   set_reply_type       replies_due[$];
   int                  fail_count = 0;
   int                  idle_left = 0;
   bit                  no_idling = 1'b0;

   union_find_rank_path_compression_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .rsp_strobe     (rsp_strobe),
      .rsp_root_a     (rsp_root_a),
      .rsp_root_b     (rsp_root_b),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count)
   );

   // Clock and the single reset pulse at the start of the run.
   always #5 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Walks from a node to its root, then points every node on the path at the root.
   function automatic logic [ufrpc_pkg::NODE_W-1:0] climb_and_flatten(
      input logic [ufrpc_pkg::NODE_W-1:0] leaf);
      logic [ufrpc_pkg::NODE_W-1:0] top;
      logic [ufrpc_pkg::NODE_W-1:0] walker;
      logic [ufrpc_pkg::NODE_W-1:0] next_hop;
      int                           steps;
      top = leaf;
      steps = 0;
      while (!shadow_is_root[top] && steps < NODES) begin
         top = shadow_parent[top];
         steps++;
      end
      walker = leaf;
      steps = 0;
      while (walker != top && !shadow_is_root[walker] && steps < NODES) begin
         next_hop = shadow_parent[walker];
         shadow_parent[walker] = top;
         walker = next_hop;
         steps++;
      end
      return top;
   endfunction

   // Applies one request to the shadow forest and returns the reply it should produce.
   function automatic set_reply_type resolve_set_request(input set_request_type req);
      set_reply_type                reply;
      int unsigned                  limit;
      logic [ufrpc_pkg::NODE_W-1:0] ra;
      logic [ufrpc_pkg::NODE_W-1:0] rb;
      reply = '0;
      limit = (shadow_count < NODES) ? shadow_count : NODES;
      if (req.node_a >= limit ||
          (req.op == ufrpc_pkg::REQ_UNION && req.node_b >= limit)) begin
         reply.status = ufrpc_pkg::STATUS_RANGE_ERR;
         return reply;
      end
      ra = climb_and_flatten(req.node_a);
      reply.root_a = ra;
      if (req.op == ufrpc_pkg::REQ_FIND) begin
         reply.status = ufrpc_pkg::STATUS_FIND_DONE;
         return reply;
      end
      rb = climb_and_flatten(req.node_b);
      reply.root_b = rb;
      if (ra == rb) begin
         reply.status = ufrpc_pkg::STATUS_SAME_SET;
         return reply;
      end
      // The lower rank goes under the higher; on a tie node_a's root goes under node_b's.
      if (shadow_rank[ra] > shadow_rank[rb]) begin
         shadow_parent[rb] = ra;
         shadow_is_root[rb] = 1'b0;
      end else begin
         shadow_parent[ra] = rb;
         shadow_is_root[ra] = 1'b0;
         if (shadow_rank[ra] == shadow_rank[rb] && shadow_rank[rb] < ufrpc_pkg::RANK_MAX)
            shadow_rank[rb] = shadow_rank[rb] + 1'b1;
      end
      reply.status = ufrpc_pkg::STATUS_JOINED;
      return reply;
   endfunction

   // Driver: predicts each transfer as it happens and presents the next request.
   always @(posedge clock) begin
      set_request_type next_req;
      if (!reset) begin
         if (start && !busy)
            replies_due.push_back(resolve_set_request({req_type, req_node_a, req_node_b}));
         if (!start || !busy) begin
            if (idle_left != 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               next_req = request_backlog.pop_front();
               req_type <= next_req.op;
               req_node_a <= next_req.node_a;
               req_node_b <= next_req.node_b;
               start <= 1'b1;
               if (!no_idling && $urandom_range(0, 99) < 25)
                  idle_left = $urandom_range(1, 7);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed reply is checked against the oldest prediction.
   always @(posedge clock) begin
      set_reply_type want;
      if (!reset && rsp_strobe) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected reply: expected none, actual root_a %0d root_b %0d status %0d",
                     $time, rsp_root_a, rsp_root_b, rsp_status);
            fail_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_root_a !== want.root_a) begin
               $display("%0t: root_a mismatch: expected %0d, actual %0d",
                        $time, want.root_a, rsp_root_a);
               fail_count++;
            end
            if (rsp_root_b !== want.root_b) begin
               $display("%0t: root_b mismatch: expected %0d, actual %0d",
                        $time, want.root_b, rsp_root_b);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic queue_request(input logic op, input int a, input int b);
      request_backlog.push_back({op, ufrpc_pkg::NODE_W'(a), ufrpc_pkg::NODE_W'(b)});
   endtask

   // Waits until every request has been sent and every reply has come back.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (request_backlog.size() != 0 || start || replies_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Drains the block, then writes the node count register through its own channel.
   task automatic set_node_count(input logic [ufrpc_pkg::COUNT_W-1:0] value);
      wait_for_drain();
      @(posedge clock);
      csr_node_count <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_count = value;
   endtask

   // Mostly well-formed requests inside the active range, with some unrestricted noise.
   task automatic queue_random_requests(input int amount);
      int unsigned limit;
      limit = (shadow_count < NODES) ? shadow_count : NODES;
      repeat (amount) begin
         if (limit != 0 && $urandom_range(0, 99) < 85)
            queue_request(($urandom_range(0, 9) < 6) ? ufrpc_pkg::REQ_UNION : ufrpc_pkg::REQ_FIND,
                          $urandom_range(0, limit - 1), $urandom_range(0, limit - 1));
         else
            queue_request(1'($urandom_range(0, 1)), $urandom_range(0, NODES - 1),
                          $urandom_range(0, NODES - 1));
      end
   endtask

   // Stimulus: directed cases first, then random phases over several node counts.
   initial begin
      logic [ufrpc_pkg::COUNT_W-1:0] phase_counts [10];
      for (int i = 0; i < NODES; i++) begin
         shadow_parent[i] = '0;
         shadow_is_root[i] = 1'b1;
         shadow_rank[i] = '0;
      end
      shadow_count = ufrpc_pkg::COUNT_RESET;
      wait (!reset);

      // Extreme indices, both link directions, equal ranks and an already-joined pair.
      queue_request(ufrpc_pkg::REQ_FIND, 0, 0);
      queue_request(ufrpc_pkg::REQ_FIND, 1023, 0);
      queue_request(ufrpc_pkg::REQ_UNION, 0, 1023);
      queue_request(ufrpc_pkg::REQ_UNION, 1023, 0);
      queue_request(ufrpc_pkg::REQ_UNION, 1, 2);
      queue_request(ufrpc_pkg::REQ_UNION, 2, 1023);
      queue_request(ufrpc_pkg::REQ_UNION, 5, 1023);
      queue_request(ufrpc_pkg::REQ_UNION, 1023, 6);
      queue_request(ufrpc_pkg::REQ_FIND, 1, 0);
      queue_request(ufrpc_pkg::REQ_UNION, 3, 900);
      queue_request(ufrpc_pkg::REQ_UNION, 682, 341);
      queue_request(ufrpc_pkg::REQ_FIND, 682, 1023);
      queue_request(ufrpc_pkg::REQ_UNION, 3, 682);

      // A lowered count still walks through links to nodes now out of range.
      set_node_count(11'd8);
      queue_request(ufrpc_pkg::REQ_FIND, 3, 0);
      queue_request(ufrpc_pkg::REQ_FIND, 8, 0);
      queue_request(ufrpc_pkg::REQ_UNION, 3, 9);
      queue_request(ufrpc_pkg::REQ_UNION, 9, 3);
      queue_request(ufrpc_pkg::REQ_FIND, 7, 1023);
      queue_request(ufrpc_pkg::REQ_UNION, 0, 3);

      // With a zero count every index is rejected.
      set_node_count(11'd0);
      queue_request(ufrpc_pkg::REQ_FIND, 0, 0);
      queue_request(ufrpc_pkg::REQ_UNION, 0, 0);

      // Random phases; a count above the store size is clipped to it.
      phase_counts = '{11'd2047, 11'd1, 11'd16, 11'd1024, 11'd100,
                       11'd2, 11'd1000, 11'd512, 11'd37, 11'd1024};
      phase_counts[7] = ufrpc_pkg::COUNT_W'($urandom_range(3, 1024));
      foreach (phase_counts[i]) begin
         set_node_count(phase_counts[i]);
         if (i == 9)
            no_idling = 1'b1;
         queue_random_requests(145);
      end

      wait_for_drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/ufrpc_pkg.sv
rtl/union_find_rank_path_compression_top.sv
tb/sv/tb_union_find_rank_path_compression_top.sv
